@@ rtl/rcht_pkg.sv @@
// ----------------------------------------------------------------------------
// rcht_pkg
// Types and constants shared by the chunk header tracker and its checker.
// ----------------------------------------------------------------------------
package rcht_pkg;

  // Input word: one 8-byte chunk header candidate plus slot select.
  typedef struct packed {
    logic [7:0]  lead_byte;
    logic [23:0] time_bytes;
    logic [23:0] length_bytes;
    logic [7:0]  media_byte;
    logic        slot_select;
  } in_t;

  // Result word.
  typedef struct packed {
    logic        accepted;
    logic        matched_slot;
    logic [1:0]  header_kind;
    logic [7:0]  slot_separator;
    logic [7:0]  slot_residual;
    logic [23:0] slot_length;
    logic [23:0] slot_timestamp;
    logic [7:0]  down_separator;
    logic [7:0]  up_separator;
  } out_t;

  // Direction mode register codes
  localparam logic [1:0] MODE_CLIENT = 2'd0;
  localparam logic [1:0] MODE_SERVER = 2'd1;
  localparam logic [1:0] MODE_NOSEP  = 2'd2;
  localparam logic [1:0] MODE_BOTH   = 2'd3;

  // Reported header kinds (also stored slot kinds, minus the reject code)
  localparam logic [1:0] KIND_FULL   = 2'd0;
  localparam logic [1:0] KIND_SHORT  = 2'd1;
  localparam logic [1:0] KIND_STAMP  = 2'd2;
  localparam logic [1:0] KIND_REJECT = 2'd3;

  // Lead byte high nibble codes
  localparam logic [3:0] NIB_FULL  = 4'h0;
  localparam logic [3:0] NIB_SHORT = 4'h4;
  localparam logic [3:0] NIB_STAMP = 4'h8;

  // Media types
  localparam logic [7:0] MEDIA_AUDIO = 8'd8;
  localparam logic [7:0] MEDIA_VIDEO = 8'd9;
  localparam logic [7:0] MEDIA_MIN   = 8'd2;
  localparam logic [7:0] MEDIA_MAX   = 8'h1F;

  localparam logic [7:0] SEP_BASE = 8'hC0;

  // Residual divisors
  localparam logic [8:0] DIV_AUDIO = 9'd65;
  localparam logic [7:0] DIV_OTHER = 8'd128;
  localparam int unsigned MAX_RESIDUAL = 128;

endpackage

@@ rtl/rtmp_chunk_header_tracker_top.sv @@
// ----------------------------------------------------------------------------
// rtmp_chunk_header_tracker_top
// Chunk header classifier with two slots of per-stream state.
// ----------------------------------------------------------------------------
// The result word is registered and valid in the cycle after its input word is accepted.
// Throughput: 1 word per cycle; slot state updates at the accept edge, so a
//   following word sees it with no bubble. One output register, in_ready
//   drops only while a result is held by out_ready low.
// Reset (rst, synchronous, active high): slot state, separators, direction
//   mode and out_valid clear to zero.
// ----------------------------------------------------------------------------
module rtmp_chunk_header_tracker_top (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  rcht_pkg::in_t       in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output rcht_pkg::out_t      out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [1:0]          cfg_data
);

  // --------------------------------------------------------------------------
  // State
  // --------------------------------------------------------------------------
  logic [1:0]  direction_mode;
  logic [1:0]  slot_kind       [2];
  logic [4:0]  slot_media      [2];
  logic [23:0] slot_stamp      [2];
  logic [23:0] slot_msg_length [2];
  logic [7:0]  slot_sep        [2];
  logic [7:0]  slot_rest       [2];
  logic [7:0]  av_separators   [2];

  logic [1:0]  slot_kind_next       [2];
  logic [4:0]  slot_media_next      [2];
  logic [23:0] slot_stamp_next      [2];
  logic [23:0] slot_msg_length_next [2];
  logic [7:0]  slot_sep_next        [2];
  logic [7:0]  slot_rest_next       [2];
  logic [7:0]  av_separators_next   [2];

  rcht_pkg::out_t out_next;

  logic in_fire;

  assign cfg_ready = 1'b1;
  assign in_ready  = !out_valid || out_ready;
  assign in_fire   = in_valid && in_ready;

  // --------------------------------------------------------------------------
  // Header decode
  // --------------------------------------------------------------------------
  logic [3:0] kind_nib;
  logic [3:0] chan_nib;
  logic       full_hit;
  logic       stamp_cand;
  logic       match0;
  logic       match1;
  logic       stamp_hit;
  logic       stamp_slot;
  logic       res_slot;

  assign kind_nib = in_data.lead_byte[7:4];
  assign chan_nib = in_data.lead_byte[3:0];

  // Full header: nibble 0 or 4, top timestamp byte zero, media 2..31
  assign full_hit = (kind_nib == rcht_pkg::NIB_FULL || kind_nib == rcht_pkg::NIB_SHORT)
                 && (in_data.time_bytes[23:16] == 8'h00)
                 && (in_data.media_byte >= rcht_pkg::MEDIA_MIN)
                 && (in_data.media_byte <= rcht_pkg::MEDIA_MAX);

  // Timestamp-only header needs at least one separator set; slot 0 wins ties
  assign stamp_cand = (kind_nib == rcht_pkg::NIB_STAMP)
                   && (slot_sep[0] != 8'h00 || slot_sep[1] != 8'h00);
  assign match0     = (slot_sep[0][3:0] == chan_nib);
  assign match1     = (slot_sep[1][3:0] == chan_nib);
  assign stamp_hit  = stamp_cand && (match0 || match1);
  assign stamp_slot = !match0;

  // --------------------------------------------------------------------------
  // Residual: length mod 65 (audio) or mod 128, zero mapped to the divisor.
  // 64 == -1 (mod 65), so alternate-sign 6-bit digit sum, then at most
  // three conditional subtracts on a 9-bit value.
  // --------------------------------------------------------------------------
  logic [8:0] fold65;
  logic [8:0] mod65;
  logic [7:0] rest_audio;
  logic [7:0] rest_other;
  logic [7:0] rest_val;

  always_comb begin
    // +130 keeps the sum non-negative (range 4..256)
    fold65 = 9'd130
           + {3'b000, in_data.length_bytes[5:0]}
           + {3'b000, in_data.length_bytes[17:12]}
           - {3'b000, in_data.length_bytes[11:6]}
           - {3'b000, in_data.length_bytes[23:18]};
    priority if (fold65 >= 9'(3 * rcht_pkg::DIV_AUDIO)) begin
      mod65 = fold65 - 9'(3 * rcht_pkg::DIV_AUDIO);
    end else if (fold65 >= 9'(2 * rcht_pkg::DIV_AUDIO)) begin
      mod65 = fold65 - 9'(2 * rcht_pkg::DIV_AUDIO);
    end else if (fold65 >= rcht_pkg::DIV_AUDIO) begin
      mod65 = fold65 - rcht_pkg::DIV_AUDIO;
    end else begin
      mod65 = fold65;
    end
  end

  assign rest_audio = (mod65 == 9'd0) ? rcht_pkg::DIV_AUDIO[7:0] : mod65[7:0];
  assign rest_other = (in_data.length_bytes[6:0] == 7'd0) ? rcht_pkg::DIV_OTHER
                                                         : {1'b0, in_data.length_bytes[6:0]};
  assign rest_val   = (in_data.media_byte == rcht_pkg::MEDIA_AUDIO) ? rest_audio : rest_other;

  // Separator candidates (8-bit wrap)
  logic [7:0] sep_own;
  logic [7:0] sep_m1;
  logic [7:0] sep_m2;

  assign sep_own = rcht_pkg::SEP_BASE + {4'h0, chan_nib};
  assign sep_m1  = sep_own - 8'd1;
  assign sep_m2  = sep_own - 8'd2;

  // --------------------------------------------------------------------------
  // Next state
  // --------------------------------------------------------------------------
  always_comb begin
    for (int i = 0; i < 2; i++) begin
      slot_kind_next[i]       = slot_kind[i];
      slot_media_next[i]      = slot_media[i];
      slot_stamp_next[i]      = slot_stamp[i];
      slot_msg_length_next[i] = slot_msg_length[i];
      slot_sep_next[i]        = slot_sep[i];
      slot_rest_next[i]       = slot_rest[i];
      av_separators_next[i]   = av_separators[i];
    end

    if (full_hit) begin
      for (int i = 0; i < 2; i++) begin
        if (in_data.slot_select == 1'(i)) begin
          slot_kind_next[i]       = (kind_nib == rcht_pkg::NIB_FULL) ? rcht_pkg::KIND_FULL
                                                                      : rcht_pkg::KIND_SHORT;
          slot_media_next[i]      = in_data.media_byte[4:0];
          slot_stamp_next[i]      = in_data.time_bytes;
          slot_msg_length_next[i] = in_data.length_bytes;
          if (direction_mode != rcht_pkg::MODE_NOSEP) begin
            slot_sep_next[i]  = sep_own;
            slot_rest_next[i] = rest_val;
          end
        end
      end
      // video on slot 0 marks slot 1 as its audio companion
      if (in_data.media_byte == rcht_pkg::MEDIA_VIDEO && !in_data.slot_select) begin
        slot_media_next[1] = rcht_pkg::MEDIA_AUDIO[4:0];
      end
      if (!in_data.slot_select) begin
        priority if (direction_mode == rcht_pkg::MODE_CLIENT) begin
          slot_sep_next[1] = sep_m2;
        end else if (direction_mode == rcht_pkg::MODE_SERVER) begin
          slot_sep_next[1] = sep_m1;
        end else if (direction_mode == rcht_pkg::MODE_BOTH) begin
          slot_sep_next[1]      = rcht_pkg::SEP_BASE;
          av_separators_next[0] = sep_m1;
          av_separators_next[1] = sep_m2;
        end else begin
          slot_sep_next[1] = slot_sep[1];
        end
      end
    end else if (stamp_hit) begin
      for (int i = 0; i < 2; i++) begin
        if (stamp_slot == 1'(i)) begin
          slot_kind_next[i]  = rcht_pkg::KIND_STAMP;
          slot_stamp_next[i] = in_data.time_bytes;
          if (slot_media[i] == rcht_pkg::MEDIA_AUDIO[4:0]) begin
            slot_msg_length_next[i] = 24'd0;
            slot_rest_next[i]       = 8'd0;
          end
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result word, read from the updated slot
  // --------------------------------------------------------------------------
  assign res_slot = (!full_hit && stamp_hit) ? stamp_slot : in_data.slot_select;

  always_comb begin
    out_next.accepted     = full_hit || stamp_hit;
    out_next.matched_slot = res_slot;
    priority if (full_hit) begin
      out_next.header_kind = (kind_nib == rcht_pkg::NIB_FULL) ? rcht_pkg::KIND_FULL
                                                               : rcht_pkg::KIND_SHORT;
    end else if (stamp_hit) begin
      out_next.header_kind = rcht_pkg::KIND_STAMP;
    end else begin
      out_next.header_kind = rcht_pkg::KIND_REJECT;
    end
    out_next.slot_separator = res_slot ? slot_sep_next[1]        : slot_sep_next[0];
    out_next.slot_residual  = res_slot ? slot_rest_next[1]       : slot_rest_next[0];
    out_next.slot_length    = res_slot ? slot_msg_length_next[1] : slot_msg_length_next[0];
    out_next.slot_timestamp = res_slot ? slot_stamp_next[1]      : slot_stamp_next[0];
    out_next.down_separator = av_separators_next[0];
    out_next.up_separator   = av_separators_next[1];
  end

  // --------------------------------------------------------------------------
  // Registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      direction_mode <= rcht_pkg::MODE_CLIENT;
      out_valid      <= 1'b0;
      for (int i = 0; i < 2; i++) begin
        slot_kind[i]       <= 2'd0;
        slot_media[i]      <= 5'd0;
        slot_stamp[i]      <= 24'd0;
        slot_msg_length[i] <= 24'd0;
        slot_sep[i]        <= 8'd0;
        slot_rest[i]       <= 8'd0;
        av_separators[i]   <= 8'd0;
      end
    end else begin
      if (cfg_valid && cfg_ready) begin
        direction_mode <= cfg_data;
      end
      if (in_fire) begin
        out_valid <= 1'b1;
        for (int i = 0; i < 2; i++) begin
          slot_kind[i]       <= slot_kind_next[i];
          slot_media[i]      <= slot_media_next[i];
          slot_stamp[i]      <= slot_stamp_next[i];
          slot_msg_length[i] <= slot_msg_length_next[i];
          slot_sep[i]        <= slot_sep_next[i];
          slot_rest[i]       <= slot_rest_next[i];
          av_separators[i]   <= av_separators_next[i];
        end
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // result payload, no reset needed
  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_data <= out_next;
    end
  end

endmodule

@@ rtl/rcht_checker.sv @@
// ----------------------------------------------------------------------------
// rcht_checker
// Port-level checks for the chunk header tracker, bound to the top level.
// ----------------------------------------------------------------------------
module rcht_checker (
  input logic           clk,
  input logic           rst,
  input logic           in_valid,
  input logic           in_ready,
  input logic           out_valid,
  input logic           out_ready,
  input rcht_pkg::out_t out_data
);

  // a held result blocks new input words
  a_stall_blocks_input: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !in_ready)
    else $error("input taken while result stalled");

  // every accepted input word yields a result word next cycle
  a_accept_gives_result: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> out_valid)
    else $error("accepted word produced no result");

  // accepted flag and kind code agree
  a_kind_vs_accept: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.accepted == (out_data.header_kind != rcht_pkg::KIND_REJECT)))
    else $error("accepted flag disagrees with header kind");

  // residual never exceeds the larger divisor
  a_residual_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.slot_residual <= 8'(rcht_pkg::MAX_RESIDUAL)))
    else $error("residual out of range");

  // nothing valid right after reset
  a_reset_clears: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result valid after reset");

endmodule

bind rtmp_chunk_header_tracker_top rcht_checker u_rcht_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
